>>> hdl/scc_pkg.sv
`default_nettype none

package scc_pkg;

  // Pipeline depth: one load enable per register stage.
  localparam int unsigned NUM_STAGES = 6;
  typedef logic [NUM_STAGES-1:0] scc_ld_t;

  // Field widths
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned YEAR_W  = 12;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned MDAY_W  = 5;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned SEC_W   = 6;
  localparam int unsigned WDAY_W  = 3;

  // Internal widths
  localparam int unsigned DAYS_W = 16;  // whole days since the epoch, up to 49710
  localparam int unsigned TOD_W  = 17;  // second of the day, below 86400
  localparam int unsigned C_W    = 16;  // day within the century
  localparam int unsigned CENT_W = 2;   // century step above the first one reached
  localparam int unsigned Q7_W   = 14;  // weekday quotient
  localparam int unsigned Q60_W  = 11;  // minute of the day
  localparam int unsigned D_W    = 7;   // year within the century
  localparam int unsigned E_W    = 9;   // day within the March-based year
  localparam int unsigned M_W    = 4;   // March-based month

  // Calendar constants
  localparam int unsigned JDN_EPOCH = 2440588;
  localparam int unsigned JDN_BIAS  = 32044;
  localparam int unsigned JDN_A0    = JDN_EPOCH + JDN_BIAS;
  localparam int unsigned CYC400    = 146097;
  localparam int unsigned CYC4      = 1461;
  localparam int unsigned MON5      = 153;
  localparam int unsigned B_FIRST   = 67;    // lowest century quotient in range

  // Days since the epoch at which the quotient steps to B_FIRST+1 and B_FIRST+2
  localparam logic [DAYS_W-1:0] DAY_B1 = DAYS_W'(CYC400 * (B_FIRST + 1) / 4 - JDN_A0);
  localparam logic [DAYS_W-1:0] DAY_B2 = DAYS_W'(CYC400 * (B_FIRST + 2) / 4 - JDN_A0);
  localparam logic [C_W-1:0]    C_OFF0 = C_W'(JDN_A0 - CYC400 * B_FIRST / 4);
  localparam logic [DAYS_W-1:0] WD_BIAS = DAYS_W'(JDN_EPOCH % 7);
  localparam logic [YEAR_W-1:0] YEAR_BASE = YEAR_W'(100 * B_FIRST - 4800);

  // 86400 = 675 << 7; divide by 675 through a reciprocal
  localparam int unsigned DAY_SHIFT  = 7;
  localparam int unsigned HI_W       = CNT_W - DAY_SHIFT;
  localparam int unsigned R675_W     = 26;
  localparam int unsigned R675_SH    = 35;
  localparam logic [R675_W-1:0] R675_MUL = 26'd50903317;
  localparam int unsigned REM675_W   = TOD_W - DAY_SHIFT;

  // Divide by 7
  localparam int unsigned R7_SH = 19;
  localparam logic [16:0] R7_MUL = 17'd74899;

  // Divide by 60 as a shift by two and a divide by 15
  localparam int unsigned R15A_SH = 18;
  localparam logic [14:0] R15A_MUL = 15'd17477;
  localparam int unsigned R15B_SH = 16;
  localparam logic [12:0] R15B_MUL = 13'd4370;

  // Divide by 1461, 153 and 5
  localparam int unsigned R1461_SH = 28;
  localparam logic [17:0] R1461_MUL = 18'd183735;
  localparam int unsigned R153_SH = 18;
  localparam logic [10:0] R153_MUL = 11'd1714;
  localparam int unsigned R5_SH = 13;
  localparam logic [10:0] R5_MUL = 11'd1639;

  // March-based month at which the year rolls over
  localparam logic [M_W-1:0] M_WRAP = 4'd10;

endpackage

`default_nettype wire

>>> hdl/scc_day_split.sv
`default_nettype none

// Stages 1-2: split the count into whole days and second of day, then
// place the day in its century and prepare the weekday quotient.
module scc_day_split import scc_pkg::*; (
  input  logic              clk_i,
  input  scc_ld_t           ld_i,
  input  logic [CNT_W-1:0]  seconds_count_i,
  output logic [TOD_W-1:0]  tod_o,
  output logic [C_W-1:0]    c_o,
  output logic [CENT_W-1:0] cent_o,
  output logic [DAYS_W-1:0] wd_y_o,
  output logic [Q7_W-1:0]   wd_q_o
);

  localparam int unsigned P1_W = HI_W + R675_W;
  localparam int unsigned P2_W = HI_W;
  localparam int unsigned P7_W = DAYS_W + 17;

  logic [P1_W-1:0]   prod1;
  logic [DAYS_W-1:0] days_d, days_q;
  logic [CNT_W-1:0]  cnt_q;

  logic [P2_W-1:0]   days675;
  logic [P2_W-1:0]   rem_full;
  logic [TOD_W-1:0]  tod_d, tod_q;
  logic [C_W-1:0]    c_d, c_q;
  logic [CENT_W-1:0] cent_d, cent_q;
  logic [DAYS_W-1:0] y_d, y_q;
  logic [P7_W-1:0]   prod7;
  logic [Q7_W-1:0]   q7_d, q7_q;

  // Stage 1: days = (count >> 7) / 675
  assign prod1  = P1_W'(seconds_count_i[CNT_W-1:DAY_SHIFT]) * P1_W'(R675_MUL);
  assign days_d = prod1[R675_SH +: DAYS_W];

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      days_q <= days_d;
      cnt_q  <= seconds_count_i;
    end
  end

  // Stage 2
  assign days675  = P2_W'(days_q) * P2_W'(675);
  assign rem_full = cnt_q[CNT_W-1:DAY_SHIFT] - days675;
  assign tod_d    = {rem_full[REM675_W-1:0], cnt_q[DAY_SHIFT-1:0]};

  always_comb begin
    if (days_q >= DAY_B2) begin
      cent_d = 2'd2;
      c_d    = days_q - DAY_B2;
    end else if (days_q >= DAY_B1) begin
      cent_d = 2'd1;
      c_d    = days_q - DAY_B1;
    end else begin
      cent_d = 2'd0;
      c_d    = days_q + C_OFF0;
    end
  end

  assign y_d   = days_q + WD_BIAS;
  assign prod7 = P7_W'(y_d) * P7_W'(R7_MUL);
  assign q7_d  = prod7[R7_SH +: Q7_W];

  always_ff @(posedge clk_i) begin
    if (ld_i[1]) begin
      tod_q  <= tod_d;
      c_q    <= c_d;
      cent_q <= cent_d;
      y_q    <= y_d;
      q7_q   <= q7_d;
    end
  end

  assign tod_o  = tod_q;
  assign c_o    = c_q;
  assign cent_o = cent_q;
  assign wd_y_o = y_q;
  assign wd_q_o = q7_q;

endmodule

`default_nettype wire

>>> hdl/scc_clock.sv
`default_nettype none

// Stages 3-6: second of day into hours, minutes and seconds.
module scc_clock import scc_pkg::*; (
  input  logic              clk_i,
  input  scc_ld_t           ld_i,
  input  logic [TOD_W-1:0]  tod_i,
  output logic [HOUR_W-1:0] hours_o,
  output logic [MIN_W-1:0]  minutes_o,
  output logic [SEC_W-1:0]  seconds_o
);

  localparam int unsigned PA_W = TOD_W - 2 + 15;
  localparam int unsigned PB_W = Q60_W - 2 + 13;

  logic [PA_W-1:0]   prod_a;
  logic [Q60_W-1:0]  q60_d, q60_3_q, q60_4_q;
  logic [TOD_W-1:0]  tod3_q;

  logic [TOD_W-1:0]  sec_full;
  logic [PB_W-1:0]   prod_b;
  logic [SEC_W-1:0]  sec4_q, sec5_q, sec6_q;
  logic [HOUR_W-1:0] hr_d, hr4_q, hr5_q, hr6_q;

  logic [Q60_W-1:0]  min_full;
  logic [MIN_W-1:0]  min5_q, min6_q;

  // Stage 3: minute of day
  assign prod_a = PA_W'(tod_i[TOD_W-1:2]) * PA_W'(R15A_MUL);
  assign q60_d  = prod_a[R15A_SH +: Q60_W];

  always_ff @(posedge clk_i) begin
    if (ld_i[2]) begin
      tod3_q  <= tod_i;
      q60_3_q <= q60_d;
    end
  end

  // Stage 4: seconds and hours
  assign sec_full = tod3_q - TOD_W'(q60_3_q) * TOD_W'(60);
  assign prod_b   = PB_W'(q60_3_q[Q60_W-1:2]) * PB_W'(R15B_MUL);
  assign hr_d     = prod_b[R15B_SH +: HOUR_W];

  always_ff @(posedge clk_i) begin
    if (ld_i[3]) begin
      sec4_q  <= sec_full[SEC_W-1:0];
      hr4_q   <= hr_d;
      q60_4_q <= q60_3_q;
    end
  end

  // Stage 5: minutes
  assign min_full = q60_4_q - Q60_W'(hr4_q) * Q60_W'(60);

  always_ff @(posedge clk_i) begin
    if (ld_i[4]) begin
      sec5_q <= sec4_q;
      hr5_q  <= hr4_q;
      min5_q <= min_full[MIN_W-1:0];
    end
  end

  // Stage 6: hold for the output word
  always_ff @(posedge clk_i) begin
    if (ld_i[5]) begin
      sec6_q <= sec5_q;
      hr6_q  <= hr5_q;
      min6_q <= min5_q;
    end
  end

  assign hours_o   = hr6_q;
  assign minutes_o = min6_q;
  assign seconds_o = sec6_q;

endmodule

`default_nettype wire

>>> hdl/scc_date.sv
`default_nettype none

// Stages 3-6: day within the century into year, month, day and weekday.
module scc_date import scc_pkg::*; (
  input  logic               clk_i,
  input  scc_ld_t            ld_i,
  input  logic [C_W-1:0]     c_i,
  input  logic [CENT_W-1:0]  cent_i,
  input  logic [DAYS_W-1:0]  wd_y_i,
  input  logic [Q7_W-1:0]    wd_q_i,
  output logic [YEAR_W-1:0]  year_o,
  output logic [MONTH_W-1:0] month_o,
  output logic [MDAY_W-1:0]  mday_o,
  output logic [WDAY_W-1:0]  weekday_o
);

  localparam int unsigned X4_W  = C_W + 2;
  localparam int unsigned PD_W  = 2 * X4_W;
  localparam int unsigned X5_W  = 11;
  localparam int unsigned PM_W  = 2 * X5_W;

  logic [PD_W-1:0]    prod_d;
  logic [DAYS_W-1:0]  wd_full;
  logic [C_W-1:0]     c3_q;
  logic [D_W-1:0]     d3_q, d4_q, d5_q;
  logic [CENT_W-1:0]  cent3_q, cent4_q, cent5_q;
  logic [WDAY_W-1:0]  wd3_q, wd4_q, wd5_q, wd6_q;

  logic [X4_W-1:0]    d1461;
  logic [C_W-1:0]     e_full;
  logic [E_W-1:0]     e4_q, e5_q;

  logic [X5_W-1:0]    x5;
  logic [PM_W-1:0]    prod_m;
  logic [M_W-1:0]     m5_q;

  logic [X5_W-1:0]    t5;
  logic [PM_W-1:0]    prod_5;
  logic [E_W-1:0]     mday_full;
  logic               wrap;
  logic [YEAR_W-1:0]  year_d, year_q;
  logic [MONTH_W-1:0] month_d, month_q;
  logic [MDAY_W-1:0]  mday_q;

  // Stage 3: year within the century, weekday remainder
  assign prod_d  = PD_W'({c_i, 2'b11}) * PD_W'(R1461_MUL);
  assign wd_full = wd_y_i - DAYS_W'(wd_q_i) * DAYS_W'(7);

  always_ff @(posedge clk_i) begin
    if (ld_i[2]) begin
      c3_q    <= c_i;
      d3_q    <= prod_d[R1461_SH +: D_W];
      cent3_q <= cent_i;
      wd3_q   <= wd_full[WDAY_W-1:0];
    end
  end

  // Stage 4: day within the March-based year
  assign d1461  = X4_W'(d3_q) * X4_W'(CYC4);
  assign e_full = c3_q - d1461[X4_W-1:2];

  always_ff @(posedge clk_i) begin
    if (ld_i[3]) begin
      e4_q    <= e_full[E_W-1:0];
      d4_q    <= d3_q;
      cent4_q <= cent3_q;
      wd4_q   <= wd3_q;
    end
  end

  // Stage 5: March-based month
  assign x5     = X5_W'(e4_q) * X5_W'(5) + X5_W'(2);
  assign prod_m = PM_W'(x5) * PM_W'(R153_MUL);

  always_ff @(posedge clk_i) begin
    if (ld_i[4]) begin
      m5_q    <= prod_m[R153_SH +: M_W];
      e5_q    <= e4_q;
      d5_q    <= d4_q;
      cent5_q <= cent4_q;
      wd5_q   <= wd4_q;
    end
  end

  // Stage 6: day of month, calendar month and year
  assign t5        = X5_W'(m5_q) * X5_W'(MON5) + X5_W'(2);
  assign prod_5    = PM_W'(t5) * PM_W'(R5_MUL);
  assign mday_full = e5_q - prod_5[R5_SH +: E_W] + E_W'(1);
  assign wrap      = (m5_q >= M_WRAP);
  assign month_d   = wrap ? (m5_q - MONTH_W'(9)) : (m5_q + MONTH_W'(3));
  assign year_d    = YEAR_BASE + YEAR_W'(cent5_q) * YEAR_W'(100)
                   + YEAR_W'(d5_q) + YEAR_W'(wrap);

  always_ff @(posedge clk_i) begin
    if (ld_i[5]) begin
      year_q  <= year_d;
      month_q <= month_d;
      mday_q  <= mday_full[MDAY_W-1:0];
      wd6_q   <= wd5_q;
    end
  end

  assign year_o    = year_q;
  assign month_o   = month_q;
  assign mday_o    = mday_q;
  assign weekday_o = wd6_q;

endmodule

`default_nettype wire

>>> hdl/seconds_counter_to_calendar_core.sv
`default_nettype none

// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into the
// Gregorian date, the time of day and the weekday (0 Monday .. 6 Sunday).
// Every count in the full 32-bit range is valid, the last one lands on
// 2106-02-07 06:28:15. The block keeps no state between words: each input
// word gives exactly one output word, in order. It is a six-stage pipeline
// that takes one word per cycle while in_stall_o is low; the depth is set
// by the chain of reciprocal multiplies (divide by 86400, then by 1461,
// 153 and 5 for the date and by 60 twice for the clock). Each stage holds
// its own valid bit, so a stalled output only backs up as far as the
// pipeline is full: bubbles are squeezed out and the input stalls only
// when all six stages hold words. in_stall_o follows out_stall_i
// combinationally through that chain of stage enables.
module seconds_counter_to_calendar_core import scc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [CNT_W-1:0]   seconds_count_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [YEAR_W-1:0]  year_o,
  output logic [MONTH_W-1:0] month_o,
  output logic [MDAY_W-1:0]  day_of_month_o,
  output logic [HOUR_W-1:0]  hours_o,
  output logic [MIN_W-1:0]   minutes_o,
  output logic [SEC_W-1:0]   seconds_of_minute_o,
  output logic [WDAY_W-1:0]  weekday_o
);

  logic [NUM_STAGES-1:0] vld_d, vld_q;
  scc_ld_t               ld;

  logic [TOD_W-1:0]      tod;
  logic [C_W-1:0]        cyc_day;
  logic [CENT_W-1:0]     cent;
  logic [DAYS_W-1:0]     wd_y;
  logic [Q7_W-1:0]       wd_q;

  // A stage loads when it is empty or when the stage after it loads.
  always_comb begin
    ld[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || !out_stall_i;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      ld[i] = !vld_q[i] || ld[i+1];
    end
  end

  // Advance the valid bits along with the data; hold where a stage is stuck.
  always_comb begin
    vld_d[0] = ld[0] ? in_valid_i : vld_q[0];
    for (int i = 1; i < NUM_STAGES; i++) begin
      vld_d[i] = ld[i] ? vld_q[i-1] : vld_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_stall_o  = !ld[0];
  assign out_valid_o = vld_q[NUM_STAGES-1];

  // Stages 1-2: days and second of day
  scc_day_split u_day_split (
    .clk_i           (clk_i),
    .ld_i            (ld),
    .seconds_count_i (seconds_count_i),
    .tod_o           (tod),
    .c_o             (cyc_day),
    .cent_o          (cent),
    .wd_y_o          (wd_y),
    .wd_q_o          (wd_q)
  );

  // Stages 3-6: time of day
  scc_clock u_clock (
    .clk_i     (clk_i),
    .ld_i      (ld),
    .tod_i     (tod),
    .hours_o   (hours_o),
    .minutes_o (minutes_o),
    .seconds_o (seconds_of_minute_o)
  );

  // Stages 3-6: date and weekday
  scc_date u_date (
    .clk_i     (clk_i),
    .ld_i      (ld),
    .c_i       (cyc_day),
    .cent_i    (cent),
    .wd_y_i    (wd_y),
    .wd_q_i    (wd_q),
    .year_o    (year_o),
    .month_o   (month_o),
    .mday_o    (day_of_month_o),
    .weekday_o (weekday_o)
  );

`ifndef NO_ASSERTIONS
  // The input backs up only when every stage holds a word.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&vld_q))
    else $error("input stalled with a bubble in the pipeline");

  // An accepted word lands in the first stage.
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("accepted word lost at pipeline entry");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (month_o >= MONTH_W'(1) && month_o <= MONTH_W'(12)
                     && day_of_month_o >= MDAY_W'(1)))
    else $error("month or day of month out of range");

  a_clock_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hours_o <= HOUR_W'(23) && minutes_o <= MIN_W'(59)
                     && seconds_of_minute_o <= SEC_W'(59)))
    else $error("time of day out of range");

  a_year_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (year_o >= YEAR_W'(1970) && year_o <= YEAR_W'(2106)
                     && weekday_o <= WDAY_W'(6)))
    else $error("year or weekday out of range");
`endif

endmodule

`default_nettype wire
